// ===== hdl/x86ex_pkg.sv =====
// Package for the real-mode x86 subset executor: request types, opcodes and status codes.
`timescale 1ns / 1ps

package x86ex_pkg;

	// Opcodes of the supported subset
	localparam logic [7:0] OP_OR_RM8_R8   = 8'h08;
	localparam logic [7:0] OP_MOV_SREG    = 8'h8E;
	localparam logic [7:0] OP_LODSB       = 8'hAC;
	localparam logic [7:0] OP_LODSW       = 8'hAD;
	localparam logic [7:0] OP_JZ_REL8     = 8'h74;
	localparam logic [7:0] OP_JMP_REL8    = 8'hEB;
	localparam logic [7:0] OP_INT         = 8'hCD;
	localparam logic [7:0] OP_MOV_R8_LO   = 8'hB0;
	localparam logic [7:0] OP_MOV_R8_HI   = 8'hB7;
	localparam logic [7:0] OP_MOV_R16_LO  = 8'hB8;
	localparam logic [7:0] OP_MOV_R16_HI  = 8'hBF;

	// ModRM mod value for the register form
	localparam logic [1:0] MOD_REG = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_AX = 3'd0;
	localparam logic [2:0] REG_SI = 3'd6;
	localparam logic [2:0] SEG_CS = 3'd1;
	localparam logic [2:0] SEG_DS = 3'd3;
	localparam logic [2:0] SEG_LAST = 3'd5;
	localparam int unsigned NUM_GPR = 8;
	localparam int unsigned NUM_SEG = 6;

	// Status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_OPCODE  = 3'd1;
	localparam logic [2:0] ST_BAD_MODE    = 3'd2;
	localparam logic [2:0] ST_BAD_SEGMENT = 3'd3;
	localparam logic [2:0] ST_INTERRUPT   = 3'd4;
	localparam logic [2:0] ST_HALTED      = 3'd5;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [7:0]  imm_high;
		logic [15:0] load_data;
	} x86ex_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  interrupt_number;
		logic [20:0] next_fetch_address;
		logic [20:0] string_load_address;
		logic [15:0] accumulator;
		logic        zero_flag;
		logic        sign_flag;
		logic        parity_flag;
	} x86ex_rsp_t;

endpackage

// ===== hdl/real_mode_x86_subset_executor_top.sv =====
// Real-mode x86 subset executor: decode, register update and two-entry result buffer.
`timescale 1ns / 1ps

// Executes one pre-fetched real-mode instruction per request (OR r/m8,r8 register form,
// MOV Sreg,r16 register form, LODSB/LODSW, JZ/JMP rel8, MOV reg,imm and INT n) and returns
// one result per request in order. Decode and the register file read-modify-write happen
// in the cycle a request is accepted, and the result lands in an output register backed
// by a one-entry skid buffer, so a request can be taken every cycle while out_ready is high
// and one more while a result waits. Any decode error halts the block; afterwards every
// request returns the halted status and changes nothing until reset. cfg_data is the
// string direction flag (1 makes LODS decrement SI); write it only while no result is
// outstanding. cfg_ready is always high.
module real_mode_x86_subset_executor_top import x86ex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  x86ex_req_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output x86ex_rsp_t out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	// Architectural state
	logic [15:0] gpr_q [NUM_GPR];
	logic [15:0] seg_q [NUM_SEG];
	logic [15:0] ip_q;
	logic        zf_q, sf_q, pf_q;
	logic        halted_q;
	logic        dir_down_q;

	// Result buffer
	x86ex_rsp_t  main_q, skid_q;
	logic        main_vld_q, skid_vld_q;

	// Next-state values
	logic [15:0] gpr_n [NUM_GPR];
	logic [15:0] seg_n [NUM_SEG];
	logic [15:0] ip_n;
	logic        zf_n, sf_n, pf_n;
	logic [2:0]  status;
	logic [7:0]  vec;
	logic [15:0] len;
	logic [15:0] rel;
	logic [1:0]  modf;
	logic [2:0]  regf, rmf;
	logic [7:0]  or_val;
	logic [15:0] lods_step;
	x86ex_rsp_t  rsp;
	logic        accept, pop;

	function automatic logic [7:0] rd_byte(input logic [15:0] r [NUM_GPR], input logic [2:0] idx);
		logic [15:0] w;
		w = r[{1'b0, idx[1:0]}];
		return idx[2] ? w[15:8] : w[7:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_vld_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;
	assign pop       = main_vld_q && out_ready;

	assign modf = in_data.modrm[7:6];
	assign regf = in_data.modrm[5:3];
	assign rmf  = in_data.modrm[2:0];
	assign rel  = {{8{in_data.modrm[7]}}, in_data.modrm};
	assign or_val = rd_byte(gpr_q, rmf) | rd_byte(gpr_q, regf);
	assign lods_step = (in_data.opcode == OP_LODSB) ? 16'd1 : 16'd2;

	// Instruction decode and execute
	always_comb begin
		gpr_n  = gpr_q;
		seg_n  = seg_q;
		ip_n   = ip_q;
		zf_n   = zf_q;
		sf_n   = sf_q;
		pf_n   = pf_q;
		status = ST_OK;
		vec    = 8'd0;
		len    = 16'd1;
		if (halted_q) begin
			status = ST_HALTED;
			len    = 16'd0;
		end else begin
			unique case (in_data.opcode) inside
				OP_OR_RM8_R8: begin
					len = 16'd2;
					if (modf != MOD_REG) begin
						status = ST_BAD_MODE;
					end else begin
						if (rmf[2])
							gpr_n[{1'b0, rmf[1:0]}][15:8] = or_val;
						else
							gpr_n[{1'b0, rmf[1:0]}][7:0] = or_val;
						zf_n = (or_val == 8'd0);
						sf_n = or_val[7];
						pf_n = ~^or_val;
					end
				end
				OP_MOV_SREG: begin
					len = 16'd2;
					if (modf != MOD_REG)
						status = ST_BAD_MODE;
					else if (regf > SEG_LAST)
						status = ST_BAD_SEGMENT;
					else
						seg_n[regf] = gpr_q[rmf];
				end
				OP_LODSB, OP_LODSW: begin
					if (in_data.opcode == OP_LODSB)
						gpr_n[REG_AX][7:0] = in_data.load_data[7:0];
					else
						gpr_n[REG_AX] = in_data.load_data;
					if (dir_down_q)
						gpr_n[REG_SI] = gpr_q[REG_SI] - lods_step;
					else
						gpr_n[REG_SI] = gpr_q[REG_SI] + lods_step;
				end
				OP_JZ_REL8, OP_JMP_REL8: begin
					len = 16'd2;
					if (in_data.opcode == OP_JMP_REL8 || zf_q)
						ip_n = ip_q + rel;
				end
				[OP_MOV_R8_LO:OP_MOV_R8_HI]: begin
					len = 16'd2;
					if (in_data.opcode[2])
						gpr_n[{1'b0, in_data.opcode[1:0]}][15:8] = in_data.modrm;
					else
						gpr_n[{1'b0, in_data.opcode[1:0]}][7:0] = in_data.modrm;
				end
				[OP_MOV_R16_LO:OP_MOV_R16_HI]: begin
					len = 16'd3;
					gpr_n[in_data.opcode[2:0]] = {in_data.imm_high, in_data.modrm};
				end
				OP_INT: begin
					len    = 16'd2;
					status = ST_INTERRUPT;
					vec    = in_data.modrm;
				end
				default: status = ST_BAD_OPCODE;
			endcase
		end
		ip_n = ip_n + len;
	end

	// Result fields from the updated state
	always_comb begin
		rsp.status              = status;
		rsp.interrupt_number    = vec;
		rsp.next_fetch_address  = {1'b0, seg_n[SEG_CS], 4'd0} + {5'd0, ip_n};
		rsp.string_load_address = {1'b0, seg_n[SEG_DS], 4'd0} + {5'd0, gpr_n[REG_SI]};
		rsp.accumulator         = gpr_n[REG_AX];
		rsp.zero_flag           = zf_n;
		rsp.sign_flag           = sf_n;
		rsp.parity_flag         = pf_n;
	end

	// Architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GPR; i++) gpr_q[i] <= 16'd0;
			for (int i = 0; i < NUM_SEG; i++) seg_q[i] <= 16'd0;
			ip_q       <= 16'd0;
			zf_q       <= 1'b0;
			sf_q       <= 1'b0;
			pf_q       <= 1'b0;
			halted_q   <= 1'b0;
			dir_down_q <= 1'b0;
		end else begin
			if (cfg_valid)
				dir_down_q <= cfg_data;
			if (accept) begin
				gpr_q <= gpr_n;
				seg_q <= seg_n;
				ip_q  <= ip_n;
				zf_q  <= zf_n;
				sf_q  <= sf_n;
				pf_q  <= pf_n;
				if (status == ST_BAD_OPCODE || status == ST_BAD_MODE ||
				    status == ST_BAD_SEGMENT)
					halted_q <= 1'b1;
			end
		end
	end

	// Result buffer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					main_vld_q <= accept;
				end
			end else if (accept) begin
				if (main_vld_q)
					skid_vld_q <= 1'b1;
				else
					main_vld_q <= 1'b1;
			end
		end
	end

	// Result buffer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q)
				main_q <= skid_q;
			else if (accept)
				main_q <= rsp;
		end else if (accept) begin
			if (main_vld_q)
				skid_q <= rsp;
			else
				main_q <= rsp;
		end
	end

endmodule

// ===== dv/real_mode_x86_subset_executor_top_tb.sv =====
// Self-checking testbench for the real-mode x86 subset executor top level.
`timescale 1ns / 1ps

module real_mode_x86_subset_executor_top_tb;
	import x86ex_pkg::*;

	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT = 5000;

	// Kinds of entries in the stimulus queue
	typedef enum logic [1:0] {
		CMD_REQ,
		CMD_CFG,
		CMD_PHASE,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct {
		cmd_kind_t  kind;
		x86ex_req_t req;
		logic       cfg_val;
		int         idle_pct;
		int         stall_pct;
	} cmd_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	x86ex_req_t in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	x86ex_rsp_t out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data  = 1'b0;

	// Stimulus and scoreboard
	cmd_t       instr_q[$];
	x86ex_rsp_t pending_rsp_q[$];
	int         inflight    = 0;
	int         quiet_cnt   = 0;
	int         idle_pct    = 0;
	int         stall_pct   = 0;
	int         fail_cnt    = 0;
	int         rsp_cnt     = 0;
	int         stuck_cnt   = 0;

	// Shadow architectural state
	logic [15:0] gpr  [NUM_GPR] = '{default: '0};
	logic [15:0] sreg [NUM_SEG] = '{default: '0};
	logic [15:0] ip       = '0;
	logic        zf       = 1'b0;
	logic        sf       = 1'b0;
	logic        pf       = 1'b0;
	logic        halted   = 1'b0;
	logic        dir_down = 1'b0;

	real_mode_x86_subset_executor_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Byte alias access: 0..3 low bytes of AX..BX, 4..7 high bytes
	function automatic logic [7:0] byte_reg_rd(input logic [2:0] idx);
		return idx[2] ? gpr[{1'b0, idx[1:0]}][15:8] : gpr[{1'b0, idx[1:0]}][7:0];
	endfunction

	function automatic void byte_reg_wr(input logic [2:0] idx, input logic [7:0] v);
		if (idx[2])
			gpr[{1'b0, idx[1:0]}][15:8] = v;
		else
			gpr[{1'b0, idx[1:0]}][7:0] = v;
	endfunction

	// Executes one instruction on the shadow state and returns the result it must produce
	function automatic x86ex_rsp_t execute_instr(input x86ex_req_t rq);
		x86ex_rsp_t rs;
		logic [2:0]  st;
		logic [7:0]  vec;
		logic [7:0]  res;
		logic [15:0] len;
		logic [15:0] rel;
		logic [15:0] stride;
		logic [1:0]  md;
		logic [2:0]  rg;
		logic [2:0]  rmi;
		st     = ST_OK;
		vec    = '0;
		len    = 16'd1;
		md     = rq.modrm[7:6];
		rg     = rq.modrm[5:3];
		rmi    = rq.modrm[2:0];
		rel    = {{8{rq.modrm[7]}}, rq.modrm};
		stride = (rq.opcode == OP_LODSB) ? 16'd1 : 16'd2;
		if (halted) begin
			st  = ST_HALTED;
			len = '0;
		end else if (rq.opcode == OP_OR_RM8_R8) begin
			len = 16'd2;
			if (md != MOD_REG) begin
				st = ST_BAD_MODE;
			end else begin
				res = byte_reg_rd(rmi) | byte_reg_rd(rg);
				byte_reg_wr(rmi, res);
				zf = (res == 8'h00);
				sf = res[7];
				pf = ~^res;
			end
		end else if (rq.opcode == OP_MOV_SREG) begin
			len = 16'd2;
			if (md != MOD_REG)
				st = ST_BAD_MODE;
			else if (rg > SEG_LAST)
				st = ST_BAD_SEGMENT;
			else
				sreg[rg] = gpr[rmi];
		end else if (rq.opcode == OP_LODSB || rq.opcode == OP_LODSW) begin
			if (rq.opcode == OP_LODSB)
				byte_reg_wr(REG_AX, rq.load_data[7:0]);
			else
				gpr[REG_AX] = rq.load_data;
			gpr[REG_SI] = dir_down ? gpr[REG_SI] - stride : gpr[REG_SI] + stride;
		end else if (rq.opcode == OP_JZ_REL8 || rq.opcode == OP_JMP_REL8) begin
			len = 16'd2;
			if (rq.opcode == OP_JMP_REL8 || zf)
				ip = ip + rel;
		end else if (rq.opcode >= OP_MOV_R8_LO && rq.opcode <= OP_MOV_R8_HI) begin
			len = 16'd2;
			byte_reg_wr(rq.opcode[2:0], rq.modrm);
		end else if (rq.opcode >= OP_MOV_R16_LO && rq.opcode <= OP_MOV_R16_HI) begin
			len = 16'd3;
			gpr[rq.opcode[2:0]] = {rq.imm_high, rq.modrm};
		end else if (rq.opcode == OP_INT) begin
			len = 16'd2;
			st  = ST_INTERRUPT;
			vec = rq.modrm;
		end else begin
			st = ST_BAD_OPCODE;
		end
		ip = ip + len;
		if (st == ST_BAD_OPCODE || st == ST_BAD_MODE || st == ST_BAD_SEGMENT)
			halted = 1'b1;
		rs.status              = st;
		rs.interrupt_number    = vec;
		rs.next_fetch_address  = {1'b0, sreg[SEG_CS], 4'h0} + {5'h00, ip};
		rs.string_load_address = {1'b0, sreg[SEG_DS], 4'h0} + {5'h00, gpr[REG_SI]};
		rs.accumulator         = gpr[REG_AX];
		rs.zero_flag           = zf;
		rs.sign_flag           = sf;
		rs.parity_flag         = pf;
		return rs;
	endfunction

	// Well-formed instruction with random content; never halts the block
	function automatic x86ex_req_t rand_instr();
		x86ex_req_t rq;
		int unsigned pick;
		rq.opcode    = OP_INT;
		rq.modrm     = 8'($urandom);
		rq.imm_high  = 8'($urandom);
		rq.load_data = 16'($urandom);
		if ($urandom_range(7) == 0)
			rq.load_data = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		pick = $urandom_range(99);
		if (pick < 14) begin
			rq.opcode      = OP_OR_RM8_R8;
			rq.modrm[7:6]  = MOD_REG;
		end else if (pick < 24) begin
			rq.opcode      = OP_MOV_SREG;
			rq.modrm[7:6]  = MOD_REG;
			rq.modrm[5:3]  = 3'($urandom_range(SEG_LAST));
		end else if (pick < 38) begin
			rq.opcode = $urandom_range(1) ? OP_LODSB : OP_LODSW;
		end else if (pick < 52) begin
			rq.opcode = OP_JZ_REL8;
		end else if (pick < 58) begin
			rq.opcode = OP_JMP_REL8;
		end else if (pick < 74) begin
			rq.opcode = OP_MOV_R8_LO | 8'($urandom_range(7));
		end else if (pick < 92) begin
			rq.opcode = OP_MOV_R16_LO | 8'($urandom_range(7));
			if ($urandom_range(3) == 0)
				{rq.imm_high, rq.modrm} = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		end
		return rq;
	endfunction

	task automatic push_req(input x86ex_req_t rq);
		cmd_t c;
		c.kind      = CMD_REQ;
		c.req       = rq;
		c.cfg_val   = 1'b0;
		c.idle_pct  = 0;
		c.stall_pct = 0;
		instr_q.push_back(c);
	endtask

	task automatic push_cfg(input logic v);
		cmd_t c;
		c.kind      = CMD_CFG;
		c.req       = '0;
		c.cfg_val   = v;
		c.idle_pct  = 0;
		c.stall_pct = 0;
		instr_q.push_back(c);
	endtask

	task automatic push_phase(input int idle, input int stall);
		cmd_t c;
		c.kind      = CMD_PHASE;
		c.req       = '0;
		c.cfg_val   = 1'b0;
		c.idle_pct  = idle;
		c.stall_pct = stall;
		instr_q.push_back(c);
	endtask

	// Sender holds off until every outstanding request has returned
	task automatic push_drain();
		cmd_t c;
		c.kind      = CMD_DRAIN;
		c.req       = '0;
		c.cfg_val   = 1'b0;
		c.idle_pct  = 0;
		c.stall_pct = 0;
		instr_q.push_back(c);
	endtask

	task automatic flag_error(input string msg);
		if (fail_cnt < 10)
			$display("%s", msg);
		fail_cnt++;
	endtask

	// Driver: request, config and response-ready channels
	always @(posedge clk) begin : drv
		logic nv;
		logic ncv;
		cmd_t hd;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			nv  = in_valid;
			ncv = cfg_valid;
			if (in_valid && in_ready) begin
				nv = 1'b0;
				inflight++;
			end
			if (out_valid && out_ready)
				inflight--;
			if (cfg_valid && cfg_ready)
				ncv = 1'b0;
			if (inflight == 0 && !nv && !ncv)
				quiet_cnt++;
			else
				quiet_cnt = 0;
			if (!nv && !ncv && instr_q.size() != 0) begin
				hd = instr_q[0];
				case (hd.kind)
					CMD_PHASE: begin
						idle_pct  = hd.idle_pct;
						stall_pct = hd.stall_pct;
						void'(instr_q.pop_front());
					end
					CMD_DRAIN: begin
						if (quiet_cnt >= SETTLE_CYCLES)
							void'(instr_q.pop_front());
					end
					CMD_CFG: begin
						if (quiet_cnt >= SETTLE_CYCLES) begin
							ncv = 1'b1;
							cfg_data <= hd.cfg_val;
							void'(instr_q.pop_front());
						end
					end
					default: begin
						if ($urandom_range(99) >= idle_pct) begin
							nv = 1'b1;
							in_data <= hd.req;
							void'(instr_q.pop_front());
						end
					end
				endcase
			end
			in_valid  <= nv;
			cfg_valid <= ncv;
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: predict on accepted requests, check accepted results, watchdog
	always @(posedge clk) begin : mon
		x86ex_rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				dir_down = cfg_data;
			if (in_valid && in_ready)
				pending_rsp_q.push_back(execute_instr(in_data));
			if (out_valid && out_ready) begin
				if (pending_rsp_q.size() == 0) begin
					flag_error($sformatf("result %0d arrived with no request outstanding",
						rsp_cnt));
				end else begin
					want = pending_rsp_q.pop_front();
					if (out_data !== want)
						flag_error($sformatf({"result %0d mismatch: got st=%0d int=%02h ",
							"fetch=%06h str=%06h ax=%04h zsp=%b%b%b, want st=%0d int=%02h ",
							"fetch=%06h str=%06h ax=%04h zsp=%b%b%b"}, rsp_cnt,
							out_data.status, out_data.interrupt_number,
							out_data.next_fetch_address, out_data.string_load_address,
							out_data.accumulator, out_data.zero_flag, out_data.sign_flag,
							out_data.parity_flag, want.status, want.interrupt_number,
							want.next_fetch_address, want.string_load_address,
							want.accumulator, want.zero_flag, want.sign_flag,
							want.parity_flag));
				end
				rsp_cnt++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stuck_cnt = 0;
			else
				stuck_cnt++;
			if (stuck_cnt >= WATCHDOG_LIMIT) begin
				$display("real_mode_x86_subset_executor_top regression: fail");
				$finish;
			end
		end
	end

	// Stimulus plan, reset and end of run
	initial begin : plan
		x86ex_req_t bad;
		// Directed: extremes, every instruction, flag cases, jumps, segment loads
		push_cfg(1'b0);
		push_phase(0, 0);
		push_req({OP_MOV_R16_LO, 8'hFF, 8'hFF, 16'h0000});            // AX = FFFF
		push_req({OP_LODSB, 8'h00, 8'h00, 16'h1234});                 // AL only
		push_req({OP_LODSW, 8'hFF, 8'hFF, 16'hFFFF});
		push_req({OP_MOV_R8_LO + 8'd1, 8'h80, 8'h00, 16'h0000});      // CL = 80
		push_req({OP_MOV_R8_LO + 8'd5, 8'hFF, 8'h00, 16'h0000});      // CH = FF
		push_req({OP_OR_RM8_R8, {MOD_REG, 3'd5, 3'd1}, 8'h00, 16'h0000}); // OR CL,CH
		push_req({OP_MOV_R8_LO + 8'd3, 8'h00, 8'h00, 16'h0000});      // BL = 0
		push_req({OP_OR_RM8_R8, {MOD_REG, 3'd3, 3'd3}, 8'h00, 16'h0000}); // zero result
		push_req({OP_JZ_REL8, 8'h7F, 8'h00, 16'h0000});               // taken, forward max
		push_req({OP_JZ_REL8, 8'h80, 8'h00, 16'h0000});               // taken, back max
		push_req({OP_MOV_R8_LO + 8'd2, 8'h01, 8'h00, 16'h0000});      // DL = 01
		push_req({OP_OR_RM8_R8, {MOD_REG, 3'd2, 3'd2}, 8'h00, 16'h0000}); // odd parity
		push_req({OP_JZ_REL8, 8'h10, 8'h00, 16'h0000});               // not taken
		push_req({OP_JMP_REL8, 8'hFE, 8'h00, 16'h0000});              // jump to itself
		push_req({OP_MOV_R16_LO + 8'd2, 8'hFF, 8'hFF, 16'h0000});     // DX = FFFF
		push_req({OP_MOV_SREG, {MOD_REG, SEG_DS, 3'd2}, 8'h00, 16'h0000});
		push_req({OP_MOV_SREG, {MOD_REG, SEG_CS, 3'd2}, 8'h00, 16'h0000}); // top of memory
		push_req({OP_MOV_SREG, {MOD_REG, SEG_LAST, 3'd0}, 8'h00, 16'h0000});
		push_req({OP_INT, 8'h00, 8'h00, 16'h0000});
		push_req({OP_INT, 8'hFF, 8'hFF, 16'hFFFF});
		push_req({OP_MOV_R16_HI, 8'h55, 8'hAA, 16'h0000});            // DI = AA55
		// Descending string loads wrapping SI below zero
		push_drain();
		push_cfg(1'b1);
		push_req({OP_MOV_R16_LO + 8'd6, 8'h00, 8'h00, 16'h0000});     // SI = 0
		push_req({OP_LODSB, 8'h00, 8'h00, 16'h00FF});
		push_req({OP_LODSW, 8'h00, 8'h00, 16'h8001});
		push_req({OP_MOV_R16_LO + 8'd6, 8'h01, 8'h00, 16'h0000});     // SI = 1
		push_req({OP_LODSW, 8'h00, 8'h00, 16'h0000});
		// Random phases with different flow-control pressure
		push_drain();
		push_cfg(1'b0);
		push_phase(0, 0);
		repeat (190) push_req(rand_instr());
		push_drain();
		push_cfg(1'b1);
		push_phase(88, 0);
		repeat (190) push_req(rand_instr());
		push_drain();
		push_cfg(1'b0);
		push_phase(0, 88);
		repeat (190) push_req(rand_instr());
		push_drain();
		push_cfg(1'($urandom_range(1)));
		push_phase(26, 26);
		repeat (170) push_req(rand_instr());
		// One decode error halts the block for the rest of the run
		bad = rand_instr();
		case ($urandom_range(3))
			0: begin
				do
					bad.opcode = 8'($urandom);
				while (bad.opcode == OP_OR_RM8_R8 || bad.opcode == OP_MOV_SREG ||
					bad.opcode == OP_LODSB || bad.opcode == OP_LODSW ||
					bad.opcode == OP_JZ_REL8 || bad.opcode == OP_JMP_REL8 ||
					bad.opcode == OP_INT ||
					(bad.opcode >= OP_MOV_R8_LO && bad.opcode <= OP_MOV_R16_HI));
			end
			1: begin
				bad.opcode     = OP_OR_RM8_R8;
				bad.modrm[7:6] = 2'($urandom_range(2));
			end
			2: begin
				bad.opcode     = OP_MOV_SREG;
				bad.modrm[7:6] = 2'($urandom_range(2));
			end
			default: begin
				bad.opcode     = OP_MOV_SREG;
				bad.modrm[7:6] = MOD_REG;
				bad.modrm[5:3] = SEG_LAST + 3'($urandom_range(1, 2));
			end
		endcase
		push_req(bad);
		// Anything after the halt returns the halted status
		repeat (12) push_req({8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (instr_q.size() != 0 || in_valid || cfg_valid || inflight != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_rsp_q.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_rsp_q.size()));
		if (fail_cnt == 0)
			$display("real_mode_x86_subset_executor_top regression: pass");
		else
			$display("real_mode_x86_subset_executor_top regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/x86ex_pkg.sv
hdl/real_mode_x86_subset_executor_top.sv
dv/real_mode_x86_subset_executor_top_tb.sv
